[rtl/dirty_tracked_config_shadow_top_macros.svh]
// Assertion macros for the configuration shadow checker.
// Needs clk and arst_n in the scope where a macro is used.
`ifndef DIRTY_TRACKED_CONFIG_SHADOW_TOP_MACROS_SVH
`define DIRTY_TRACKED_CONFIG_SHADOW_TOP_MACROS_SVH

// check cons in the same cycle as ante
`define DTCS_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// check cons in the cycle after ante
`define DTCS_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[rtl/dtcs_pkg.sv]
// Shared types, codes and parameter defaults of the configuration shadow.
// No dependencies.
package dtcs_pkg;

	localparam int TILES_DEF = 4;
	localparam int ROWS_DEF  = 8;
	localparam int COLS_DEF  = 16;
	localparam int LINES_DEF = 16;

	localparam logic KIND_WRITE = 1'b0;
	localparam logic KIND_FLUSH = 1'b1;

	typedef enum logic [1:0] {
		ST_STORED = 2'd0,
		ST_REJECT = 2'd1,
		ST_EMIT   = 2'd2,
		ST_EMPTY  = 2'd3
	} status_t;

	typedef struct packed {
		logic       kind;
		logic [1:0] tile;
		logic [3:0] row;
		logic [3:0] col;
		logic [3:0] line;
		logic [7:0] data;
	} item_t;

	typedef struct packed {
		status_t    status;
		logic [1:0] out_tile;
		logic [2:0] out_row;
		logic [3:0] out_col;
		logic [3:0] out_line;
		logic [7:0] out_data;
	} result_t;

	typedef enum logic [3:0] {
		S_CLEAR,
		S_IDLE,
		S_W_RD,
		S_W_UPD,
		S_F_TOP,
		S_F_SUM,
		S_F_COL,
		S_F_DRD,
		S_F_LINE,
		S_F_SRD,
		S_F_UPD,
		S_DONE
	} state_t;

	typedef struct packed {
		logic    clear;
		logic    accept;
		logic    w_upd;
		logic    f_top;
		logic    f_col;
		logic    f_line;
		logic    f_upd;
		logic    res_load;
		status_t res_code;
	} cmd_t;

	typedef struct packed {
		logic clear_last;
		logic reject;
		logic flush;
		logic any_dirty;
	} sts_t;

	function automatic int fw(int n);
		return (n > 1) ? $clog2(n) : 1;
	endfunction

endpackage

[rtl/dtcs_ctrl.sv]
// Sequencer of the configuration shadow: clearing pass, write and flush steps.
// Depends on dtcs_pkg; drives the datapath through cmd_t, reads sts_t.
module dtcs_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	output logic            busy,
	output logic            done,
	output dtcs_pkg::cmd_t  cmd,
	input  dtcs_pkg::sts_t  sts
);
	import dtcs_pkg::*;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		busy    = (state_q != S_IDLE);
		done    = (state_q == S_DONE);
		unique case (state_q)
			S_CLEAR: begin
				cmd.clear = 1'b1;
				if (sts.clear_last) state_d = S_IDLE;
			end
			S_IDLE: begin
				if (start) begin
					cmd.accept = 1'b1;
					if (sts.flush) begin
						if (sts.any_dirty) begin
							state_d = S_F_TOP;
						end else begin
							cmd.res_load = 1'b1;
							cmd.res_code = ST_EMPTY;
							state_d      = S_DONE;
						end
					end else if (sts.reject) begin
						cmd.res_load = 1'b1;
						cmd.res_code = ST_REJECT;
						state_d      = S_DONE;
					end else begin
						state_d = S_W_RD;
					end
				end
			end
			S_W_RD: state_d = S_W_UPD;
			S_W_UPD: begin
				cmd.w_upd    = 1'b1;
				cmd.res_load = 1'b1;
				cmd.res_code = ST_STORED;
				state_d      = S_DONE;
			end
			S_F_TOP: begin
				cmd.f_top = 1'b1;
				state_d   = S_F_SUM;
			end
			S_F_SUM: state_d = S_F_COL;
			S_F_COL: begin
				cmd.f_col = 1'b1;
				state_d   = S_F_DRD;
			end
			S_F_DRD: state_d = S_F_LINE;
			S_F_LINE: begin
				cmd.f_line = 1'b1;
				state_d    = S_F_SRD;
			end
			S_F_SRD: state_d = S_F_UPD;
			S_F_UPD: begin
				cmd.f_upd    = 1'b1;
				cmd.res_load = 1'b1;
				cmd.res_code = ST_EMIT;
				state_d      = S_DONE;
			end
			S_DONE: state_d = S_IDLE;
			default: state_d = S_CLEAR;
		endcase
	end

endmodule

[rtl/dtcs_dp.sv]
// Datapath of the configuration shadow: byte store, dirty words, column summary,
// tile/row summary flops, first-set searches and result register. Depends on dtcs_pkg.
module dtcs_dp #(
	parameter int TILES = dtcs_pkg::TILES_DEF,
	parameter int ROWS  = dtcs_pkg::ROWS_DEF,
	parameter int COLS  = dtcs_pkg::COLS_DEF,
	parameter int LINES = dtcs_pkg::LINES_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  dtcs_pkg::item_t   item,
	input  dtcs_pkg::cmd_t    cmd,
	output dtcs_pkg::sts_t    sts,
	output dtcs_pkg::result_t result
);
	import dtcs_pkg::*;

	localparam int TW   = fw(TILES);
	localparam int RW   = fw(ROWS);
	localparam int CW   = fw(COLS);
	localparam int LW   = fw(LINES);
	localparam int TRW  = TW + RW;
	localparam int AWW  = TRW + CW;
	localparam int AWS  = AWW + LW;
	localparam int PC   = 2 ** CW;
	localparam int PL   = 2 ** LW;
	localparam int NTOP = 2 ** TRW;
	localparam logic [PC-1:0] COL_MASK  = PC'((65'd1 << COLS) - 65'd1);
	localparam logic [PL-1:0] LINE_MASK = PL'((65'd1 << LINES) - 65'd1);

	logic [7:0]      sh_mem [2**AWS];
	logic [2*PL-1:0] dw_mem [2**AWW];
	logic [PC-1:0]   sum_mem [NTOP];

	item_t           item_q;
	result_t         result_q;
	logic [AWW-1:0]  clr_cnt_q;
	logic [NTOP-1:0] top_q;
	logic [TRW-1:0]  sel_tr_q;
	logic [CW-1:0]   sel_c_q;
	logic [LW-1:0]   sel_l_q;
	logic [PC-1:0]   sum_word_q;
	logic [2*PL-1:0] dw_word_q;
	logic [7:0]      sh_rd_q;
	logic [2*PL-1:0] dw_rd_q;
	logic [PC-1:0]   sum_rd_q;

	logic [TW-1:0]   it_t, cl_t;
	logic [RW-1:0]   it_r, cl_r;
	logic [CW-1:0]   it_c, cl_c;
	logic [LW-1:0]   it_l;
	logic            flush_q, cl_tr_ok, cl_ok;
	logic [AWW-1:0]  it_waddr;
	logic [TRW-1:0]  sum_raddr;
	logic [AWW-1:0]  dw_raddr;
	logic [AWS-1:0]  sh_raddr;
	logic [PL-1:0]   w_wr_bits, w_dirty, f_wr_bits, f_dirty_new;
	logic [PC-1:0]   f_sum_new;
	logic [7:0]      w_stored, f_byte;
	logic            differ, f_word_empty, f_sum_empty;
	logic            dw_we, sum_we;
	logic [AWW-1:0]  dw_waddr;
	logic [2*PL-1:0] dw_wdata;
	logic [TRW-1:0]  sum_waddr;
	logic [PC-1:0]   sum_wdata;
	logic [TRW-1:0]  top_first;
	logic [CW-1:0]   col_first;
	logic [LW-1:0]   line_first;

	assign it_t     = TW'(item_q.tile);
	assign it_r     = RW'(item_q.row);
	assign it_c     = CW'(item_q.col);
	assign it_l     = LW'(item_q.line);
	assign it_waddr = {it_t, it_r, it_c};
	assign flush_q  = (item_q.kind == KIND_FLUSH);

	assign cl_t     = clr_cnt_q[AWW-1 -: TW];
	assign cl_r     = clr_cnt_q[CW +: RW];
	assign cl_c     = clr_cnt_q[CW-1:0];
	assign cl_tr_ok = (32'(cl_t) < TILES) && (32'(cl_r) < ROWS);
	assign cl_ok    = cl_tr_ok && (32'(cl_c) < COLS);

	assign sts.clear_last = &clr_cnt_q;
	assign sts.flush      = (item.kind == KIND_FLUSH);
	assign sts.any_dirty  = |top_q;
	assign sts.reject     = (32'(item.tile) >= TILES) || (32'(item.row) >= ROWS)
		|| (32'(item.col) >= COLS) || (32'(item.line) >= LINES);

	assign sum_raddr = flush_q ? sel_tr_q : {it_t, it_r};
	assign dw_raddr  = flush_q ? {sel_tr_q, sel_c_q} : it_waddr;
	assign sh_raddr  = flush_q ? {sel_tr_q, sel_c_q, sel_l_q} : {it_waddr, it_l};

	assign w_wr_bits = dw_rd_q[2*PL-1:PL];
	assign w_dirty   = dw_rd_q[PL-1:0];
	assign w_stored  = w_wr_bits[it_l] ? sh_rd_q : 8'h00;
	assign differ    = (w_stored != item_q.data);

	assign f_wr_bits    = dw_word_q[2*PL-1:PL];
	assign f_dirty_new  = dw_word_q[PL-1:0] & ~(PL'(1) << sel_l_q);
	assign f_sum_new    = sum_word_q & ~(PC'(1) << sel_c_q);
	assign f_byte       = f_wr_bits[sel_l_q] ? sh_rd_q : 8'h00;
	assign f_word_empty = (f_dirty_new == '0);
	assign f_sum_empty  = (f_sum_new == '0);

	always_comb begin
		top_first = '0;
		for (int i = NTOP - 1; i >= 0; i--) begin
			if (top_q[i]) top_first = TRW'(i);
		end
		col_first = '0;
		for (int i = PC - 1; i >= 0; i--) begin
			if (sum_rd_q[i]) col_first = CW'(i);
		end
		line_first = '0;
		for (int i = PL - 1; i >= 0; i--) begin
			if (dw_rd_q[i]) line_first = LW'(i);
		end
	end

	always_comb begin
		dw_we     = 1'b0;
		dw_waddr  = it_waddr;
		dw_wdata  = {w_wr_bits | (PL'(1) << it_l), w_dirty | (PL'(1) << it_l)};
		sum_we    = 1'b0;
		sum_waddr = {it_t, it_r};
		sum_wdata = sum_rd_q | (PC'(1) << it_c);
		if (cmd.clear) begin
			dw_we     = 1'b1;
			dw_waddr  = clr_cnt_q;
			dw_wdata  = {{PL{1'b0}}, (cl_ok ? LINE_MASK : {PL{1'b0}})};
			sum_we    = 1'b1;
			sum_waddr = clr_cnt_q[AWW-1:CW];
			sum_wdata = cl_tr_ok ? COL_MASK : {PC{1'b0}};
		end else if (cmd.w_upd) begin
			dw_we  = differ;
			sum_we = differ;
		end else if (cmd.f_upd) begin
			dw_we     = 1'b1;
			dw_waddr  = {sel_tr_q, sel_c_q};
			dw_wdata  = {f_wr_bits, f_dirty_new};
			sum_we    = f_word_empty;
			sum_waddr = sel_tr_q;
			sum_wdata = f_sum_new;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.w_upd && differ) sh_mem[{it_waddr, it_l}] <= item_q.data;
		sh_rd_q <= sh_mem[sh_raddr];
	end

	always_ff @(posedge clk) begin
		if (dw_we) dw_mem[dw_waddr] <= dw_wdata;
		dw_rd_q <= dw_mem[dw_raddr];
	end

	always_ff @(posedge clk) begin
		if (sum_we) sum_mem[sum_waddr] <= sum_wdata;
		sum_rd_q <= sum_mem[sum_raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_cnt_q <= '0;
			top_q     <= '0;
		end else begin
			if (cmd.clear) begin
				clr_cnt_q <= clr_cnt_q + AWW'(1);
				if (cl_tr_ok) top_q[clr_cnt_q[AWW-1:CW]] <= 1'b1;
			end else if (cmd.w_upd && differ) begin
				top_q[{it_t, it_r}] <= 1'b1;
			end else if (cmd.f_upd && f_word_empty && f_sum_empty) begin
				top_q[sel_tr_q] <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) item_q <= item;
		if (cmd.f_top) sel_tr_q <= top_first;
		if (cmd.f_col) begin
			sel_c_q    <= col_first;
			sum_word_q <= sum_rd_q;
		end
		if (cmd.f_line) begin
			sel_l_q   <= line_first;
			dw_word_q <= dw_rd_q;
		end
		if (cmd.res_load) begin
			result_q        <= '0;
			result_q.status <= cmd.res_code;
			if (cmd.res_code == ST_EMIT) begin
				result_q.out_tile <= 2'(sel_tr_q[TRW-1:RW]);
				result_q.out_row  <= 3'(sel_tr_q[RW-1:0]);
				result_q.out_col  <= 4'(sel_c_q);
				result_q.out_line <= 4'(sel_l_q);
				result_q.out_data <= f_byte;
			end
		end
	end

	assign result = result_q;

endmodule

[rtl/dirty_tracked_config_shadow_top.sv]
// Top level of the write-back configuration shadow with per-byte dirty tracking.
// Depends on dtcs_pkg, dtcs_ctrl and dtcs_dp.
//
//   channel   handshake              payload
//   input     start, busy            item   (dtcs_pkg::item_t)
//   output    done (one-cycle strobe) result (dtcs_pkg::result_t)
//
// Write item: S_W_RD, S_W_UPD, then the strobe in S_DONE; a new item is taken only in S_IDLE.
// Flush step: S_F_TOP through S_F_UPD, then the strobe in S_DONE, set by the chain of registered
// reads (column summary, dirty word, byte store).
// Rejected write or empty flush: the strobe in S_DONE straight from S_IDLE.
// After reset a clearing pass over TILES*ROWS*COLS addresses, rounded up per field to
// powers of two (512 by default), walks the dirty words; busy stays high meanwhile.
// Results cannot be held off: each is shown for one cycle while busy is still high.
module dirty_tracked_config_shadow_top #(
	parameter int TILES = dtcs_pkg::TILES_DEF,
	parameter int ROWS  = dtcs_pkg::ROWS_DEF,
	parameter int COLS  = dtcs_pkg::COLS_DEF,
	parameter int LINES = dtcs_pkg::LINES_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  dtcs_pkg::item_t   item,
	output logic              done,
	output dtcs_pkg::result_t result
);
	import dtcs_pkg::*;

	cmd_t cmd;
	sts_t sts;

	dtcs_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.done   (done),
		.cmd    (cmd),
		.sts    (sts)
	);

	dtcs_dp #(
		.TILES (TILES),
		.ROWS  (ROWS),
		.COLS  (COLS),
		.LINES (LINES)
	) u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item),
		.cmd    (cmd),
		.sts    (sts),
		.result (result)
	);

endmodule

[rtl/dtcs_checker.sv]
// Port-level checks of the configuration shadow, bound to the top level.
// Depends on dtcs_pkg and the assertion macro header.
`include "dirty_tracked_config_shadow_top_macros.svh"

module dtcs_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              start,
	input logic              busy,
	input logic              done,
	input dtcs_pkg::result_t result
);
	import dtcs_pkg::*;

	`DTCS_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted transaction left busy low")
	`DTCS_ASSERT_NEXT(a_strobe_once, done, !done && !busy, "result strobe not a single cycle")
	`DTCS_ASSERT_NOW(a_done_busy, done, busy, "result shown while idle")
	`DTCS_ASSERT_NOW(a_zero_fields, done && (result.status != ST_EMIT), (result.out_tile == 2'd0) && (result.out_row == 3'd0) && (result.out_col == 4'd0) && (result.out_line == 4'd0) && (result.out_data == 8'd0), "non-flush result carries address or data")

endmodule

bind dirty_tracked_config_shadow_top dtcs_checker u_dtcs_checker (.*);

[verif/dirty_tracked_config_shadow_top_tb.sv]
// Self-checking testbench of the configuration shadow top level: a directed table,
// then random write/flush traffic checked against a local shadow model.
// Depends on dtcs_pkg and dirty_tracked_config_shadow_top.
module dirty_tracked_config_shadow_top_tb;
	import dtcs_pkg::*;

	localparam int NTILES       = TILES_DEF;
	localparam int NROWS        = ROWS_DEF;
	localparam int NCOLS        = COLS_DEF;
	localparam int NLINES       = LINES_DEF;
	localparam int DEPTH        = NTILES * NROWS * NCOLS * NLINES;
	localparam int RANDOM_ITEMS = 800;
	localparam int PHASE_LEN    = 40;
	localparam int SETTLE       = 16;
	localparam int CYCLE_LIMIT  = 1000000;
	localparam int NDIRECTED    = 18;

	typedef struct packed {
		item_t   it;
		logic    typed;
		result_t exp;
	} dir_row_t;

	localparam dir_row_t DIRECTED [NDIRECTED] = '{
		'{'{KIND_FLUSH, 2'd0, 4'd0,  4'd0,  4'd0,  8'h00}, 1'b1,
			'{ST_EMIT,   2'd0, 3'd0, 4'd0,  4'd0,  8'h00}},
		'{'{KIND_FLUSH, 2'd0, 4'd0,  4'd0,  4'd0,  8'h00}, 1'b1,
			'{ST_EMIT,   2'd0, 3'd0, 4'd0,  4'd1,  8'h00}},
		'{'{KIND_WRITE, 2'd0, 4'd8,  4'd0,  4'd0,  8'hFF}, 1'b1,
			'{ST_REJECT, 2'd0, 3'd0, 4'd0,  4'd0,  8'h00}},
		'{'{KIND_WRITE, 2'd3, 4'd10, 4'd15, 4'd15, 8'hFF}, 1'b1,
			'{ST_REJECT, 2'd0, 3'd0, 4'd0,  4'd0,  8'h00}},
		'{'{KIND_WRITE, 2'd3, 4'd15, 4'd15, 4'd15, 8'h00}, 1'b1,
			'{ST_REJECT, 2'd0, 3'd0, 4'd0,  4'd0,  8'h00}},
		'{'{KIND_WRITE, 2'd3, 4'd7,  4'd15, 4'd15, 8'hFF}, 1'b1,
			'{ST_STORED, 2'd0, 3'd0, 4'd0,  4'd0,  8'h00}},
		'{'{KIND_WRITE, 2'd0, 4'd0,  4'd0,  4'd0,  8'h00}, 1'b1,
			'{ST_STORED, 2'd0, 3'd0, 4'd0,  4'd0,  8'h00}},
		'{'{KIND_FLUSH, 2'd0, 4'd0,  4'd0,  4'd0,  8'h00}, 1'b1,
			'{ST_EMIT,   2'd0, 3'd0, 4'd0,  4'd2,  8'h00}},
		'{'{KIND_WRITE, 2'd0, 4'd0,  4'd0,  4'd0,  8'hA5}, 1'b1,
			'{ST_STORED, 2'd0, 3'd0, 4'd0,  4'd0,  8'h00}},
		'{'{KIND_FLUSH, 2'd0, 4'd0,  4'd0,  4'd0,  8'h00}, 1'b1,
			'{ST_EMIT,   2'd0, 3'd0, 4'd0,  4'd0,  8'hA5}},
		'{'{KIND_WRITE, 2'd0, 4'd0,  4'd0,  4'd1,  8'h5A}, 1'b1,
			'{ST_STORED, 2'd0, 3'd0, 4'd0,  4'd0,  8'h00}},
		'{'{KIND_WRITE, 2'd0, 4'd0,  4'd0,  4'd1,  8'h00}, 1'b1,
			'{ST_STORED, 2'd0, 3'd0, 4'd0,  4'd0,  8'h00}},
		'{'{KIND_FLUSH, 2'd0, 4'd0,  4'd0,  4'd0,  8'h00}, 1'b0, '0},
		'{'{KIND_WRITE, 2'd0, 4'd0,  4'd0,  4'd0,  8'hA5}, 1'b1,
			'{ST_STORED, 2'd0, 3'd0, 4'd0,  4'd0,  8'h00}},
		'{'{KIND_FLUSH, 2'd3, 4'd15, 4'd15, 4'd15, 8'hFF}, 1'b0, '0},
		'{'{KIND_WRITE, 2'd1, 4'd3,  4'd9,  4'd6,  8'h3C}, 1'b1,
			'{ST_STORED, 2'd0, 3'd0, 4'd0,  4'd0,  8'h00}},
		'{'{KIND_WRITE, 2'd2, 4'd4,  4'd6,  4'd9,  8'hC3}, 1'b1,
			'{ST_STORED, 2'd0, 3'd0, 4'd0,  4'd0,  8'h00}},
		'{'{KIND_WRITE, 2'd3, 4'd7,  4'd15, 4'd15, 8'h00}, 1'b1,
			'{ST_STORED, 2'd0, 3'd0, 4'd0,  4'd0,  8'h00}}
	};

	logic    clk    = 1'b0;
	logic    arst_n = 1'b0;
	logic    start  = 1'b0;
	item_t   item   = '0;
	logic    busy;
	logic    done;
	result_t result;

	logic [7:0]  shadow_bytes [DEPTH];
	logic        dirty_map [DEPTH];
	result_t     awaited_results [$];
	int unsigned mismatches = 0;
	int unsigned cycles = 0;

	dirty_tracked_config_shadow_top u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.item   (item),
		.done   (done),
		.result (result)
	);

	always #5 clk = ~clk;

	function automatic int flat_index(item_t it);
		return ((int'(it.tile) * NROWS + int'(it.row)) * NCOLS + int'(it.col)) * NLINES
			+ int'(it.line);
	endfunction

	function automatic result_t shadow_predict(item_t it);
		result_t r;
		int idx;
		r = '0;
		r.status = ST_STORED;
		if (it.kind == KIND_WRITE) begin
			if (int'(it.row) >= NROWS) begin
				r.status = ST_REJECT;
			end else begin
				idx = flat_index(it);
				if (shadow_bytes[idx] != it.data) begin
					shadow_bytes[idx] = it.data;
					dirty_map[idx] = 1'b1;
				end
			end
			return r;
		end
		r.status = ST_EMPTY;
		for (idx = 0; idx < DEPTH; idx++) begin
			if (dirty_map[idx]) begin
				dirty_map[idx] = 1'b0;
				r.status   = ST_EMIT;
				r.out_line = 4'(idx % NLINES);
				r.out_col  = 4'((idx / NLINES) % NCOLS);
				r.out_row  = 3'((idx / (NLINES * NCOLS)) % NROWS);
				r.out_tile = 2'(idx / (NLINES * NCOLS * NROWS));
				r.out_data = shadow_bytes[idx];
				return r;
			end
		end
		return r;
	endfunction

	function automatic int pick_gap(bit idle_on);
		int unsigned roll;
		if (!idle_on) return 0;
		roll = $urandom_range(99);
		if (roll < 60) return 0;
		if (roll < 95) return int'($urandom_range(3, 1));
		return int'($urandom_range(40, 10));
	endfunction

	function automatic item_t random_item(int unsigned flush_pct);
		item_t it;
		it.kind = ($urandom_range(99) < flush_pct) ? KIND_FLUSH : KIND_WRITE;
		it.tile = 2'($urandom);
		it.row  = ($urandom_range(9) == 0) ? 4'($urandom_range(15, 8)) : 4'($urandom_range(7));
		it.col  = 4'($urandom);
		it.line = 4'($urandom);
		it.data = 8'($urandom);
		if ($urandom_range(99) < 40) begin
			it.col  = 4'($urandom_range(1));
			it.line = 4'($urandom_range(1));
		end
		if ($urandom_range(9) == 0)
			it.data = $urandom_range(1) ? 8'hFF : 8'h00;
		if (it.kind == KIND_WRITE && int'(it.row) < NROWS && $urandom_range(3) == 0)
			it.data = shadow_bytes[flat_index(it)];
		return it;
	endfunction

	task automatic send_transaction(item_t it, logic typed, result_t exp, int gap);
		result_t predicted;
		start <= 1'b1;
		item  <= it;
		@(posedge clk);
		while (busy) @(posedge clk);
		predicted = shadow_predict(it);
		awaited_results.push_back(typed ? exp : predicted);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	always @(posedge clk) begin : check_results
		result_t want;
		if (arst_n && done) begin
			if (awaited_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result %h with nothing awaited", result);
			end else begin
				want = awaited_results.pop_front();
				if (result.status !== want.status || result.out_tile !== want.out_tile ||
						result.out_row !== want.out_row || result.out_col !== want.out_col ||
						result.out_line !== want.out_line ||
						result.out_data !== want.out_data) begin
					mismatches++;
					if (mismatches <= 10) begin
						$display("mismatch: expected st %0d t %0d r %0d c %0d l %0d d %h",
							want.status, want.out_tile, want.out_row, want.out_col,
							want.out_line, want.out_data);
						$display("          got      st %0d t %0d r %0d c %0d l %0d d %h",
							result.status, result.out_tile, result.out_row,
							result.out_col, result.out_line, result.out_data);
					end
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("FAIL dirty_tracked_config_shadow_top");
			$finish;
		end
	end

	initial begin : stimulus
		int sent;
		int unsigned flush_pct;
		bit idle_on;
		foreach (shadow_bytes[i]) begin
			shadow_bytes[i] = 8'h00;
			dirty_map[i] = 1'b1;
		end
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		for (int i = 0; i < NDIRECTED; i++)
			send_transaction(DIRECTED[i].it, DIRECTED[i].typed, DIRECTED[i].exp, pick_gap(1'b1));

		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			case ($urandom_range(2))
				0: flush_pct = 15;
				1: flush_pct = 50;
				default: flush_pct = 85;
			endcase
			idle_on = ($urandom_range(3) != 0);
			for (int i = 0; i < PHASE_LEN; i++) begin
				send_transaction(random_item(flush_pct), 1'b0, '0, pick_gap(idle_on));
				sent++;
			end
		end
		start <= 1'b0;

		while (awaited_results.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
		if (mismatches == 0)
			$display("PASS dirty_tracked_config_shadow_top");
		else
			$display("FAIL dirty_tracked_config_shadow_top");
		$finish;
	end

endmodule
